// ===== sv/suffix_array_kmer_search_core_assert.svh =====
// Assertion macros for the suffix array k-mer search core.
// Included by the top level; depends on nothing else.
`ifndef SUFFIX_ARRAY_KMER_SEARCH_CORE_ASSERT_SVH
`define SUFFIX_ARRAY_KMER_SEARCH_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SAKS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define SAKS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/saks_pkg.sv =====
// Package for the suffix array k-mer search core: sizes, payload types, states.
// No dependencies.
package saks_pkg;
    localparam int MaxGenome = 65536;
    localparam int MaxKmer   = 32;
    localparam int MaxHits   = 64;
    localparam int AddrW     = $clog2(MaxGenome);
    localparam int LenW      = AddrW + 1;
    localparam int KW        = $clog2(MaxKmer) + 1;
    localparam int HitW      = $clog2(MaxHits) + 1;
    localparam int CfgW      = 17;

    typedef enum logic [1:0] {
        OP_GENOME = 2'd0,
        OP_SUFFIX = 2'd1,
        OP_LCP    = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    localparam logic CFG_GENOME_LENGTH = 1'b0;
    localparam logic CFG_KMER_LENGTH   = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [15:0] load_value;
        logic [63:0] kmer_symbols;
    } in_item_t;

    typedef struct packed {
        logic [15:0] position;
        logic        found;
        logic        truncated;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SA_WAIT,
        ST_CMP_REQ,
        ST_CMP_WAIT,
        ST_UP_REQ,
        ST_UP_WAIT,
        ST_DN_REQ,
        ST_DN_WAIT,
        ST_EMIT_REQ,
        ST_EMIT_WAIT,
        ST_OUT
    } state_t;

    // Memory requests from the sequencer to the store module.
    typedef struct packed {
        logic [AddrW-1:0]  gen_addr;
        logic [AddrW-1:0]  sa_addr;
        logic [AddrW-1:0]  lcp_addr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]  gen_data;
        logic [15:0] sa_data;
        logic [15:0] lcp_data;
    } mem_rsp_t;
endpackage

// ===== sv/saks_stores.sv =====
// Genome, suffix and LCP stores with registered reads.
// Depends on saks_pkg.
module saks_stores (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [1:0]         wr_sel,
    input  logic [15:0]        wr_addr,
    input  logic [15:0]        wr_data,
    input  saks_pkg::mem_req_t req,
    output saks_pkg::mem_rsp_t rsp
);
    import saks_pkg::*;

    logic [1:0]  genome_mem [MaxGenome];
    logic [15:0] suffix_mem [MaxGenome];
    logic [15:0] lcp_mem    [MaxGenome];

    // Writes from load transfers, one store at a time.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_sel == OP_GENOME) begin
            genome_mem[wr_addr[AddrW-1:0]] <= wr_data[1:0];
        end
        if (wr_en && wr_sel == OP_SUFFIX) begin
            suffix_mem[wr_addr[AddrW-1:0]] <= wr_data;
        end
        if (wr_en && wr_sel == OP_LCP) begin
            lcp_mem[wr_addr[AddrW-1:0]] <= wr_data;
        end
    end

    // Registered reads.
    always_ff @(posedge aclk) begin
        rsp.gen_data <= genome_mem[req.gen_addr];
        rsp.sa_data  <= suffix_mem[req.sa_addr];
        rsp.lcp_data <= lcp_mem[req.lcp_addr];
    end
endmodule

// ===== sv/suffix_array_kmer_search_core.sv =====
// Top level of the suffix array k-mer search core: sequencer and handshakes.
// Depends on saks_pkg, saks_stores and suffix_array_kmer_search_core_assert.svh.
//
//  channel  | ports                         | content
//  ---------+-------------------------------+-------------------------------
//  input    | s_valid, s_ready, s_item      | load or query item
//  result   | m_valid, m_ready, m_item      | position, found, truncated, last
//  config   | cfg_we, cfg_index, cfg_wdata  | genome_length, kmer_length
//
// A load is written to its store on transfer. A query then runs search steps
// (up to log2(n) rounded up), each a suffix read and m compare rounds of one
// genome read each, at most k+1; a miss ends through ST_OUT. A hit then takes
// one LCP read per step up or down and an emit per result, stalled by m_ready.
// Reset is synchronous; the stores need no clearing. The result register
// holds while m_ready is low, and the input stays closed until the last result
// of a query has been taken.
`include "suffix_array_kmer_search_core_assert.svh"
module suffix_array_kmer_search_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  saks_pkg::in_item_t        s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output saks_pkg::out_item_t       m_item,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [saks_pkg::CfgW-1:0] cfg_wdata
);
    import saks_pkg::*;

    state_t state_reg, state_next;
    logic [LenW-1:0]  glen_reg;
    logic [KW-1:0]    klen_reg;
    logic [LenW-1:0]  n_reg, n_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [63:0]      kmer_reg, kmer_next;
    logic [LenW-1:0]  deb_reg, deb_next, fin_reg, fin_next;
    logic [LenW-1:0]  mid_reg, mid_next, j_reg, j_next;
    logic [KW-1:0]    i_reg, i_next;
    logic [LenW-1:0]  up_reg, up_next, dn_reg, dn_next;
    logic             upph_reg, upph_next;
    logic [HitW-1:0]  hits_reg, hits_next;
    logic             mv_reg, mv_next;
    out_item_t        mo_reg, mo_next;
    logic [LenW-1:0]  eidx_reg, eidx_next;
    mem_req_t         req;
    mem_rsp_t         rsp;
    logic [1:0]       qsym;
    logic [LenW-1:0]  sum;
    logic [LenW-1:0]  cfg_k;

    saks_stores u_stores (
        .aclk    (aclk),
        .wr_en   (s_valid && s_ready && s_item.opcode != OP_QUERY),
        .wr_sel  (s_item.opcode),
        .wr_addr (s_item.address),
        .wr_data (s_item.load_value),
        .req     (req),
        .rsp     (rsp)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glen_reg <= '0;
            klen_reg <= KW'(1);
        end else if (cfg_we) begin
            if (cfg_index == CFG_GENOME_LENGTH) glen_reg <= cfg_wdata[LenW-1:0];
            else klen_reg <= cfg_wdata[KW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;     k_reg <= k_next;     kmer_reg <= kmer_next;
        deb_reg <= deb_next; fin_reg <= fin_next; mid_reg <= mid_next;
        j_reg <= j_next;     i_reg <= i_next;     up_reg <= up_next;
        dn_reg <= dn_next;   upph_reg <= upph_next; hits_reg <= hits_next;
        mo_reg <= mo_next;   eidx_reg <= eidx_next;
    end

    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_item  = mo_reg;
    assign qsym    = kmer_reg[2*i_reg[KW-2:0] +: 2];
    assign sum     = deb_reg + fin_reg;
    assign cfg_k   = LenW'(klen_reg);

    // Sequencer: one memory read per step through the shared compare.
    always_comb begin
        state_next = state_reg;
        n_next = n_reg; k_next = k_reg; kmer_next = kmer_reg;
        deb_next = deb_reg; fin_next = fin_reg; mid_next = mid_reg;
        j_next = j_reg; i_next = i_reg; up_next = up_reg; dn_next = dn_reg;
        upph_next = upph_reg; hits_next = hits_reg; eidx_next = eidx_reg;
        mv_next = mv_reg && !m_ready;
        mo_next = mo_reg;
        req.gen_addr = j_reg[AddrW-1:0];
        req.sa_addr  = mid_reg[AddrW-1:0];
        req.lcp_addr = (state_reg == ST_UP_REQ) ? AddrW'(up_reg - 1'b1)
                                                : dn_reg[AddrW-1:0];
        // The suffix entry of a hit is held on the read port until it is used.
        if (state_reg == ST_EMIT_REQ || state_reg == ST_EMIT_WAIT) begin
            req.sa_addr = eidx_reg[AddrW-1:0];
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready && s_item.opcode == OP_QUERY) begin
                    n_next = (glen_reg > LenW'(MaxGenome)) ? LenW'(MaxGenome) : glen_reg;
                    k_next = (klen_reg == '0) ? KW'(1) :
                             (cfg_k > LenW'(MaxKmer)) ? KW'(MaxKmer) : klen_reg;
                    kmer_next = s_item.kmer_symbols;
                    deb_next = '0;
                    fin_next = n_next;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (fin_reg - deb_reg > LenW'(1)) begin
                    mid_next = sum >> 1;
                    req.sa_addr = AddrW'(sum >> 1);
                    state_next = ST_SA_WAIT;
                end else begin
                    mo_next = '{position: '0, found: 1'b0, truncated: 1'b0, last: 1'b1};
                    state_next = ST_OUT;
                end
            end
            ST_SA_WAIT: begin
                req.sa_addr = mid_reg[AddrW-1:0];
                state_next = ST_CMP_REQ;
            end
            ST_CMP_REQ: begin
                state_next = ST_CMP_WAIT;
            end
            ST_CMP_WAIT: begin
                if (i_reg >= k_reg) begin
                    up_next = mid_reg; dn_next = mid_reg;
                    hits_next = '0; upph_next = 1'b1;
                    state_next = ST_UP_REQ;
                end else if (j_reg >= n_reg) begin
                    deb_next = mid_reg; i_next = '0; state_next = ST_SEARCH;
                end else if (rsp.gen_data != qsym) begin
                    if (rsp.gen_data > qsym) fin_next = mid_reg;
                    else deb_next = mid_reg;
                    i_next = '0; state_next = ST_SEARCH;
                end else begin
                    i_next = i_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                    state_next = ST_CMP_REQ;
                end
            end
            ST_UP_REQ: begin
                if (up_reg == '0) begin
                    upph_next = 1'b0; eidx_next = dn_reg; state_next = ST_EMIT_REQ;
                end else state_next = ST_UP_WAIT;
            end
            ST_UP_WAIT: begin
                if (rsp.lcp_data >= 16'(k_reg)) begin
                    up_next = up_reg - 1'b1; eidx_next = up_reg - 1'b1;
                    state_next = ST_EMIT_REQ;
                end else begin
                    upph_next = 1'b0; eidx_next = dn_reg; state_next = ST_EMIT_REQ;
                end
            end
            ST_DN_REQ: state_next = ST_DN_WAIT;
            ST_DN_WAIT: begin
                if (dn_reg + 1'b1 >= n_reg || rsp.lcp_data < 16'(k_reg)) begin
                    mo_next.last = 1'b1; mv_next = 1'b1; state_next = ST_IDLE;
                end else begin
                    dn_next = dn_reg + 1'b1; eidx_next = dn_reg + 1'b1;
                    state_next = ST_EMIT_REQ;
                end
            end
            ST_EMIT_REQ: begin
                // Show pending result, truncated at the cap; the next waits.
                if (hits_reg == HitW'(MaxHits)) begin
                    mo_next.truncated = 1'b1; mo_next.last = 1'b1;
                    mv_next = 1'b1; state_next = ST_IDLE;
                end else if (hits_reg != '0) begin
                    mv_next = 1'b1; state_next = ST_EMIT_WAIT;
                end else state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (!mv_reg || m_ready) begin
                    mo_next = '{position: rsp.sa_data, found: 1'b1,
                                truncated: 1'b0, last: 1'b0};
                    mv_next = 1'b0;
                    hits_next = hits_reg + 1'b1;
                    state_next = upph_reg ? ST_UP_REQ : ST_DN_REQ;
                end
            end
            ST_OUT: begin
                mv_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_SA_WAIT) begin
            j_next = LenW'(rsp.sa_data);
            i_next = '0;
        end
    end

    `SAKS_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE, "ready outside idle")
    `SAKS_ASSERT_IMP(a_hits_cap, aclk, aresetn, 1'b1, hits_reg <= HitW'(MaxHits), "hit count overflow")
    `SAKS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result dropped")
endmodule

// ===== test/tb_suffix_array_kmer_search_core.sv =====
// Testbench for the suffix array k-mer search core: loads small genomes, runs
// queries and checks every result against a built-in search predictor.
// Depends on saks_pkg and suffix_array_kmer_search_core.
`timescale 1ns / 100ps
module tb_suffix_array_kmer_search_core;
    import saks_pkg::*;

    localparam int WatchdogLimit = 200000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_item;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [16:0]         cfg_wdata = '0;

    // Shadow copy of the stores and registers.
    logic [1:0]  genome_shadow [MaxGenome];
    logic [15:0] suffix_shadow [MaxGenome];
    logic [15:0] lcp_shadow    [MaxGenome];
    logic [16:0] len_shadow = 17'd0;
    logic [5:0]  k_shadow = 6'd1;

    out_item_t hits_pending [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        hold_off = 1'b0;
    logic [1:0] text [];

    suffix_array_kmer_search_core dut (.*);

    always #10 aclk = ~aclk;

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("tb_suffix_array_kmer_search_core: done, errors");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Expected results of one query, computed on the shadow stores.
    function automatic void predict_hits(input logic [63:0] kmer);
        int unsigned n, k, lo, hi, mid, i, j, up, dn, cnt;
        bit hit, room, over;
        out_item_t r;
        out_item_t res [$];
        n = (len_shadow > MaxGenome) ? MaxGenome : len_shadow;
        k = (k_shadow == 0) ? 1 : ((k_shadow > MaxKmer) ? MaxKmer : k_shadow);
        lo = 0; hi = n; mid = 0; hit = 0;
        while (!hit && hi - lo > 1) begin
            mid = (lo + hi) / 2;
            i = 0;
            j = suffix_shadow[mid];
            while (i < k && j < n && genome_shadow[j] == kmer[2*(i%32) +: 2]) begin
                i++; j++;
            end
            if (i >= k) hit = 1;
            else if (j >= n) lo = mid;
            else if (genome_shadow[j] > kmer[2*(i%32) +: 2]) hi = mid;
            else lo = mid;
        end
        if (!hit) begin
            r = '0;
            r.last = 1'b1;
            hits_pending = {hits_pending, r};
            return;
        end
        cnt = 0; over = 0; room = 1; up = mid;
        while (up > 0 && lcp_shadow[up-1] >= k) begin
            up--;
            if (cnt >= MaxHits) begin over = 1; room = 0; break; end
            r = '0; r.position = suffix_shadow[up]; r.found = 1'b1;
            res = {res, r}; cnt++;
        end
        if (room) begin
            dn = mid;
            forever begin
                if (cnt >= MaxHits) begin over = 1; break; end
                r = '0; r.position = suffix_shadow[dn]; r.found = 1'b1;
                res = {res, r}; cnt++;
                if (dn + 1 >= n || lcp_shadow[dn] < k) break;
                dn++;
            end
        end
        res[res.size()-1].truncated = over;
        res[res.size()-1].last = 1'b1;
        hits_pending = {hits_pending, res};
    endfunction

    // Sends one item, updating the shadow model on transfer.
    task automatic send_item(input opcode_t op, input logic [15:0] addr,
                             input logic [15:0] value, input logic [63:0] kmer);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap + 1) @(negedge aclk);
        s_item <= '{opcode: op, address: addr, load_value: value, kmer_symbols: kmer};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (op)
            OP_GENOME: genome_shadow[addr] = value[1:0];
            OP_SUFFIX: suffix_shadow[addr] = value;
            OP_LCP:    lcp_shadow[addr] = value;
            OP_QUERY:  predict_hits(kmer);
        endcase
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Result checker with random stalls and an optional long hold-off.
    initial begin
        out_item_t want;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            m_ready <= ($urandom_range(0, 9) < 6);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (hits_pending.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = hits_pending.pop_front();
                    if (m_item.position !== want.position)
                        report($sformatf("position %0d want %0d", m_item.position,
                                         want.position));
                    if (m_item.found !== want.found) report("found flag");
                    if (m_item.truncated !== want.truncated) report("truncated flag");
                    if (m_item.last !== want.last) report("last flag");
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [16:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_GENOME_LENGTH) len_shadow = value;
        else k_shadow = value[5:0];
    endtask

    task automatic wait_drained();
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Builds a genome of the given size with its suffix and LCP arrays, loads
    // it with a mix of store operations, and sets the genome length.
    task automatic load_genome(input int n, input int alpha);
        int sa [];
        int t, a, b, l;
        text = new[n];
        sa = new[n];
        foreach (text[p]) text[p] = 2'($urandom_range(0, alpha - 1));
        foreach (sa[p]) sa[p] = p;
        // Insertion sort of suffixes; the shorter prefix sorts first.
        for (int p = 1; p < n; p++) begin
            for (int q = p; q > 0; q--) begin
                a = sa[q-1]; b = sa[q]; l = 0;
                while (a + l < n && b + l < n && text[a+l] == text[b+l]) l++;
                if (a + l >= n || (b + l < n && text[a+l] < text[b+l])) break;
                t = sa[q]; sa[q] = sa[q-1]; sa[q-1] = t;
            end
        end
        for (int p = 0; p < n; p++) begin
            send_item(OP_GENOME, 16'(p), {14'($urandom_range(0, 16383)), text[p]},
                      64'($urandom()));
            send_item(OP_SUFFIX, 16'(p), 16'(sa[p]), 64'($urandom()));
            l = 0;
            if (p + 1 < n) while (sa[p]+l < n && sa[p+1]+l < n &&
                                  text[sa[p]+l] == text[sa[p+1]+l]) l++;
            send_item(OP_LCP, 16'(p), 16'(l), {$urandom(), $urandom()});
        end
        wait_drained();
        write_reg(CFG_GENOME_LENGTH, 17'(n));
    endtask

    // Query k-mer: a substring of the genome padded with random symbols, or noise.
    function automatic logic [63:0] pick_kmer(input int n);
        logic [63:0] v;
        int s;
        v = {$urandom(), $urandom()};
        if ($urandom_range(0, 3) != 0 && n > 0) begin
            s = $urandom_range(0, n - 1);
            for (int p = 0; p < 32 && s + p < n; p++) v[2*p +: 2] = text[s+p];
        end
        return v;
    endfunction

    task automatic test_directed();
        load_genome(12, 2);
        write_reg(CFG_KMER_LENGTH, 17'd0);
        send_item(OP_QUERY, 16'hFFFF, 16'hFFFF, '0);
        send_item(OP_QUERY, 16'h0, 16'h0, '1);
        send_item(OP_QUERY, 16'd0, 16'd0, 64'h1);
        wait_drained();
        write_reg(CFG_KMER_LENGTH, 17'd63);
        send_item(OP_QUERY, 16'd0, 16'd0, pick_kmer(12));
        send_item(OP_QUERY, 16'd0, 16'd0, '1);
        wait_drained();
        write_reg(CFG_KMER_LENGTH, 17'd3);
        for (int q = 0; q < 6; q++) send_item(OP_QUERY, 16'd0, 16'd0, pick_kmer(12));
        wait_drained();
        // Short genomes always miss.
        write_reg(CFG_GENOME_LENGTH, 17'd1);
        send_item(OP_QUERY, 16'd0, 16'd0, '0);
        wait_drained();
        write_reg(CFG_GENOME_LENGTH, 17'd0);
        send_item(OP_QUERY, 16'd0, 16'd0, '0);
        wait_drained();
        // An oversized length is clamped but would read unwritten entries, so
        // none is used here; a real length is restored afterwards.
        write_reg(CFG_GENOME_LENGTH, 17'd12);
    endtask

    // Many equal symbols give more matches than can be emitted.
    task automatic test_truncation();
        load_genome(70, 1);
        write_reg(CFG_KMER_LENGTH, 17'd1);
        send_item(OP_QUERY, 16'd0, 16'd0, '0);
        wait_drained();
        write_reg(CFG_KMER_LENGTH, 17'd5);
        send_item(OP_QUERY, 16'd0, 16'd0, '0);
        wait_drained();
    endtask

    // Long receiver hold-off while queries keep coming, on the uniform genome
    // left by the truncation test.
    task automatic test_backpressure();
        write_reg(CFG_KMER_LENGTH, 17'd2);
        hold_off = 1'b1;
        @(negedge aclk);
        @(negedge aclk);
        hold_off = 1'b0;
        for (int q = 0; q < 12; q++) send_item(OP_QUERY, 16'd0, 16'd0, pick_kmer(70));
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        for (int round = 0; round < 3; round++) begin
            n = $urandom_range(2, 16);
            load_genome(n, $urandom_range(2, 4));
            write_reg(CFG_KMER_LENGTH, 17'($urandom_range(0, 63)));
            for (int q = 0; q < 25; q++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(opcode_t'($urandom_range(0, 2)), 16'hFFFF,
                              16'($urandom()), 64'($urandom()));
                else
                    send_item(OP_QUERY, 16'($urandom()), 16'($urandom()),
                              pick_kmer(n));
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_truncation();
        test_backpressure();
        test_random();
        wait_drained();
        if (error_count == 0) begin
            $display("tb_suffix_array_kmer_search_core: done, clean");
        end else begin
            $display("tb_suffix_array_kmer_search_core: done, errors");
        end
        $finish;
    end
endmodule
